>>> hw/rtl/qte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and tables for the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int OP_W   = 30;   // clamped Q28 operand, covers +/-2^28
	localparam int XY_W   = 32;   // CORDIC x/y, room for gain and sqrt(2)
	localparam int ACC_W  = 28;   // angle accumulator, degrees*65536
	localparam int SQ_N   = 29;   // result bits of the square root
	localparam int REM_W  = 31;   // square root remainder
	localparam int TAB_N  = 24;   // entries of the arctangent table

	localparam logic signed [ACC_W-1:0] DEG_90  = 28'sd5898240;
	localparam logic signed [ACC_W-1:0] DEG_180 = 28'sd11796480;
	localparam logic signed [34:0]      ONE_Q28 = 35'sd268435456;
	localparam logic signed [34:0]      POLE_LIM = 35'sd268434912;
	localparam logic signed [16:0]      FULL_TURN = 17'sd46080;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_word_t;

	typedef struct packed {
		logic [15:0] angle_pitch;
		logic [15:0] angle_yaw;
		logic [15:0] angle_roll;
	} euler_word_t;

	// atan(2^-i) in degrees*65536, rounded to nearest
	function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
		logic signed [ACC_W-1:0] r;
		case (i)
			0:  r = 28'sd2949120;
			1:  r = 28'sd1740967;
			2:  r = 28'sd919879;
			3:  r = 28'sd466945;
			4:  r = 28'sd234379;
			5:  r = 28'sd117304;
			6:  r = 28'sd58666;
			7:  r = 28'sd29335;
			8:  r = 28'sd14668;
			9:  r = 28'sd7334;
			10: r = 28'sd3667;
			11: r = 28'sd1833;
			12: r = 28'sd917;
			13: r = 28'sd458;
			14: r = 28'sd229;
			15: r = 28'sd115;
			16: r = 28'sd57;
			17: r = 28'sd29;
			18: r = 28'sd14;
			19: r = 28'sd7;
			20: r = 28'sd4;
			21: r = 28'sd2;
			22: r = 28'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// clamp a wide Q28 value to [-1, 1]
	function automatic logic signed [OP_W-1:0] clamp_one(input logic signed [34:0] v);
		logic signed [34:0] r;
		if (v > ONE_Q28) begin
			r = ONE_Q28;
		end else if (v < -ONE_Q28) begin
			r = -ONE_Q28;
		end else begin
			r = v;
		end
		return r[OP_W-1:0];
	endfunction

	// clamp a Q2.14 input to [-1, 1] and scale to Q28
	function automatic logic signed [OP_W-1:0] clamp_in(input logic signed [15:0] v);
		logic signed [15:0] c;
		if (v > 16'sd16384) begin
			c = 16'sd16384;
		end else if (v < -16'sd16384) begin
			c = -16'sd16384;
		end else begin
			c = v;
		end
		return {c, 14'b0};
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/qte_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in degrees*65536.
// ----------------------------------------------------------------------------
module qte_cordic #(
	parameter int STAGES = 16
) (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire logic signed [qte_pkg::OP_W-1:0] y_in,
	input  wire logic signed [qte_pkg::OP_W-1:0] x_in,
	output logic signed [qte_pkg::ACC_W-1:0]     angle
);
	import qte_pkg::*;

	localparam int RUN = (STAGES < TAB_N) ? STAGES : TAB_N;

	logic signed [XY_W-1:0]  xv [0:RUN];
	logic signed [XY_W-1:0]  yv [0:RUN];
	logic signed [ACC_W-1:0] av [0:RUN];
	logic                    fx [0:RUN];

	logic signed [XY_W-1:0] x_ext, y_ext;
	assign x_ext = XY_W'(x_in);
	assign y_ext = XY_W'(y_in);

	// axis cases are exact and skip the iterations; left half-plane is pre-rotated
	always_ff @(posedge clk) begin
		if (en) begin
			xv[0] <= x_ext;
			yv[0] <= y_ext;
			av[0] <= '0;
			fx[0] <= 1'b0;
			if (y_in == '0) begin
				fx[0] <= 1'b1;
				av[0] <= (x_in >= 0) ? '0 : DEG_180;
			end else if (x_in == '0) begin
				fx[0] <= 1'b1;
				av[0] <= (y_in > 0) ? DEG_90 : -DEG_90;
			end else if (x_in < 0) begin
				xv[0] <= -x_ext;
				yv[0] <= -y_ext;
				av[0] <= (y_in > 0) ? DEG_180 : -DEG_180;
			end
		end
	end

	for (genvar g = 0; g < RUN; g++) begin : g_stage
		logic signed [XY_W-1:0] dx, dy;
		assign dx = yv[g] >>> g;
		assign dy = xv[g] >>> g;
		always_ff @(posedge clk) begin
			if (en) begin
				fx[g+1] <= fx[g];
				if (fx[g]) begin
					xv[g+1] <= xv[g];
					yv[g+1] <= yv[g];
					av[g+1] <= av[g];
				end else if (yv[g] > 0) begin
					xv[g+1] <= xv[g] + dx;
					yv[g+1] <= yv[g] - dy;
					av[g+1] <= av[g] + atan_deg(g);
				end else begin
					xv[g+1] <= xv[g] - dx;
					yv[g+1] <= yv[g] + dy;
					av[g+1] <= av[g] - atan_deg(g);
				end
			end
		end
	end

	assign angle = av[RUN];

endmodule
`default_nettype wire

>>> hw/rtl/quaternion_to_euler_degrees_unit.sv
`default_nettype none
// Throughput: one word per cycle; the stages run in lockstep and the output register
//   stalls the whole pipeline only while a finished word is held and stalled.
// The depth is set by the 29-step square root and the CORDIC iterations.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_unit
// Converts a Q2.14 quaternion to pitch, yaw and roll in degrees*128, [0,360).
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       quat_valid,
	output logic                      quat_stall,
	input  wire qte_pkg::quat_word_t  quat,
	output logic                      euler_valid,
	input  wire                       euler_stall,
	output qte_pkg::euler_word_t      euler
);
	import qte_pkg::*;

	localparam int RUN  = (CORDIC_STAGES < TAB_N) ? CORDIC_STAGES : TAB_N;
	localparam int CLAT = RUN + 1;   // CORDIC latency

	// advance every stage together unless the held output is stalled
	logic adv;
	assign adv        = !(euler_valid && euler_stall);
	assign quat_stall = !adv;

	// ---------------- stage 1: all pairwise products ----------------
	logic                      v_s1;
	logic signed [31:0]        pxw_s1, pyz_s1, pxz_s1, pyw_s1, pxy_s1, pzw_s1;
	logic signed [31:0]        pxx_s1, pyy_s1, pzz_s1;
	logic signed [15:0]        y_s1, z_s1, w_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pxw_s1 <= quat.quat_x * quat.quat_w;
			pyz_s1 <= quat.quat_y * quat.quat_z;
			pxz_s1 <= quat.quat_x * quat.quat_z;
			pyw_s1 <= quat.quat_y * quat.quat_w;
			pxy_s1 <= quat.quat_x * quat.quat_y;
			pzw_s1 <= quat.quat_z * quat.quat_w;
			pxx_s1 <= quat.quat_x * quat.quat_x;
			pyy_s1 <= quat.quat_y * quat.quat_y;
			pzz_s1 <= quat.quat_z * quat.quat_z;
			y_s1   <= quat.quat_y;
			z_s1   <= quat.quat_z;
			w_s1   <= quat.quat_w;
		end
	end

	// ---------------- stage 2: pitch term, poles, clamped operands ----------------
	typedef struct packed {
		logic                   pole_pos;
		logic                   pole_neg;
		logic signed [OP_W-1:0] yaw_y;
		logic signed [OP_W-1:0] yaw_x;
		logic signed [OP_W-1:0] roll_y;
		logic signed [OP_W-1:0] roll_x;
	} side_t;

	logic signed [34:0] t_c, ys_c, yc_c, rs_c, rc_c;
	logic               ppos_c, pneg_c;
	side_t              side_c, side_s2;
	logic signed [OP_W-1:0] tc_s2;
	logic               v_s2;

	always_comb begin
		t_c  = (35'(pyz_s1) - 35'(pxw_s1)) <<< 1;
		ys_c = 35'(pxz_s1) + 35'(pyw_s1);
		yc_c = (ONE_Q28 >>> 1) - 35'(pxx_s1) - 35'(pyy_s1);
		rs_c = 35'(pxy_s1) + 35'(pzw_s1);
		rc_c = (ONE_Q28 >>> 1) - 35'(pxx_s1) - 35'(pzz_s1);
		ppos_c = (t_c >= POLE_LIM);
		pneg_c = (t_c <= -POLE_LIM);
		side_c.pole_pos = ppos_c;
		side_c.pole_neg = pneg_c;
		if (ppos_c || pneg_c) begin
			side_c.yaw_y  = clamp_in(y_s1);
			side_c.yaw_x  = clamp_in(w_s1);
			side_c.roll_y = clamp_in(z_s1);
			side_c.roll_x = clamp_in(w_s1);
		end else begin
			side_c.yaw_y  = clamp_one(ys_c);
			side_c.yaw_x  = clamp_one(yc_c);
			side_c.roll_y = clamp_one(rs_c);
			side_c.roll_x = clamp_one(rc_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			tc_s2   <= clamp_one(t_c);
		end
	end

	// ---------------- stage 3: radicand 1 - t*t in Q56 ----------------
	logic [OP_W-2:0]       tmag_c;
	logic [2*OP_W-3:0]     tsq_c;
	logic [57:0]           rad_s3;
	logic signed [OP_W-1:0] tc_s3;
	side_t                 side_s3;
	logic                  v_s3;

	assign tmag_c = (tc_s2 < 0) ? (OP_W-1)'(-tc_s2) : (OP_W-1)'(tc_s2);
	assign tsq_c  = tmag_c * tmag_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= (58'd1 << 56) - 58'(tsq_c);
			tc_s3   <= tc_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------- square root: one result bit per stage ----------------
	logic [57:0]            sq_rad  [0:SQ_N];
	logic [REM_W-1:0]       sq_rem  [0:SQ_N];
	logic [SQ_N-1:0]        sq_root [0:SQ_N];
	logic signed [OP_W-1:0] sq_tc   [0:SQ_N];
	side_t                  sq_side [0:SQ_N];
	logic                   sq_v    [0:SQ_N];

	assign sq_rad[0]  = rad_s3;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_tc[0]   = tc_s3;
	assign sq_side[0] = side_s3;
	assign sq_v[0]    = v_s3;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [REM_W+1:0] cur, trial;
		logic             ge;
		assign cur   = {sq_rem[k], sq_rad[k][57:56]};
		assign trial = (REM_W+2)'({sq_root[k], 2'b01});
		assign ge    = (cur >= trial);
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad[k+1]  <= {sq_rad[k][55:0], 2'b00};
				sq_rem[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
				sq_root[k+1] <= {sq_root[k][SQ_N-2:0], ge};
				sq_tc[k+1]   <= sq_tc[k];
				sq_side[k+1] <= sq_side[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end
	end

	// ---------------- three CORDIC units in lockstep ----------------
	logic signed [ACC_W-1:0] a_pitch, a_yaw, a_roll;
	logic signed [OP_W-1:0]  cos_op;

	assign cos_op = OP_W'(sq_root[SQ_N]);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(adv), .y_in(sq_tc[SQ_N]), .x_in(cos_op), .angle(a_pitch)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(adv), .y_in(sq_side[SQ_N].yaw_y), .x_in(sq_side[SQ_N].yaw_x),
		.angle(a_yaw)
	);
	qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(adv), .y_in(sq_side[SQ_N].roll_y), .x_in(sq_side[SQ_N].roll_x),
		.angle(a_roll)
	);

	// pole flags and valid ride alongside the CORDIC
	logic cd_pos [0:CLAT];
	logic cd_neg [0:CLAT];
	logic cd_v   [0:CLAT];

	assign cd_pos[0] = sq_side[SQ_N].pole_pos;
	assign cd_neg[0] = sq_side[SQ_N].pole_neg;
	assign cd_v[0]   = sq_v[SQ_N];

	for (genvar c = 0; c < CLAT; c++) begin : g_cdly
		always_ff @(posedge clk) begin
			if (adv) begin
				cd_pos[c+1] <= cd_pos[c];
				cd_neg[c+1] <= cd_neg[c];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v[c+1] <= 1'b0;
			end else if (adv) begin
				cd_v[c+1] <= cd_v[c];
			end
		end
	end

	// ---------------- output: round to degrees*128 and wrap ----------------
	function automatic logic [15:0] to_out(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] s;
		logic signed [16:0]    r;
		s = (ACC_W+1)'(a) + 29'sd256;
		r = 17'(s >>> 9);
		if (r < 0) begin
			r = r + FULL_TURN;
		end else if (r >= FULL_TURN) begin
			r = r - FULL_TURN;
		end
		return r[15:0];
	endfunction

	logic signed [ACC_W-1:0] pitch_c;

	always_comb begin
		if (cd_pos[CLAT]) begin
			pitch_c = DEG_90;
		end else if (cd_neg[CLAT]) begin
			pitch_c = -DEG_90;
		end else begin
			pitch_c = a_pitch;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			euler.angle_pitch <= to_out(pitch_c);
			euler.angle_yaw   <= to_out(-a_yaw);
			euler.angle_roll  <= to_out(-a_roll);
		end
	end

	// ---------------- valid bits of the front stages and the output ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			euler_valid <= 1'b0;
		end else if (adv) begin
			v_s1        <= quat_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			euler_valid <= cd_v[CLAT];
		end
	end

	// ---------------- checks ----------------
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		euler_valid |-> (euler.angle_pitch < 16'd46080) && (euler.angle_yaw < 16'd46080)
			&& (euler.angle_roll < 16'd46080))
		else $error("angle outside one turn");

	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		(euler_valid && euler_stall) |-> quat_stall)
		else $error("input taken while output held");

	a_one_pole: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(side_s2.pole_pos && side_s2.pole_neg))
		else $error("both poles flagged");

	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[SQ_N] |-> (sq_root[SQ_N] <= (SQ_N)'(29'd268435456)))
		else $error("square root above one");

endmodule
`default_nettype wire
